### hw/rtl/sha512_pkg.sv
// Shared types, constants and round functions of the SHA-512 engine.
// No dependencies; compile before every other file of the block.
package sha512_pkg;

    localparam int WORD_W  = 64;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int RND_W   = 7;
    localparam int POS_W   = 4;
    localparam int ROUNDS  = 80;
    localparam int HASH_N  = 8;
    localparam int SCHED_N = 16;

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(SCHED_N - 2);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(SCHED_N - 1);
    localparam logic [CNT_W-1:0] FULL_BYTES = CNT_W'(8);
    localparam logic [WORD_W-1:0] MARK_WORD = 64'h8000_0000_0000_0000;

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_N] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Source of the word shifted into the message schedule.
    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_PADDED,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             push;
        t_src             src;
        logic             add_bytes;
        logic             load_work;
        logic             round;
        logic [RND_W-1:0] rnd;
        logic             add_hash;
        logic             publish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] v);
        big_sigma0 = rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] v);
        big_sigma1 = rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] v);
        small_sigma0 = rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] v);
        small_sigma1 = rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
    endfunction

endpackage

### hw/rtl/sha512_if.sv
// Valid/ready channel interfaces for message words and digest words.
// Depends on sha512_pkg for the field widths.
interface sha512_msg_if;
    logic                              valid;
    logic                              ready;
    logic [sha512_pkg::WORD_W-1:0]     data_word;
    logic [sha512_pkg::CNT_W-1:0]      valid_bytes;
    logic                              final_word;

    modport source (output valid, output data_word, output valid_bytes, output final_word,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input final_word,
                    output ready);
endinterface

interface sha512_dig_if;
    logic                              valid;
    logic                              ready;
    logic [sha512_pkg::WORD_W-1:0]     digest_word;
    logic [sha512_pkg::IDX_W-1:0]      digest_index;
    logic                              digest_last;

    modport source (output valid, output digest_word, output digest_index, output digest_last,
                    input ready);
    modport sink   (input valid, input digest_word, input digest_index, input digest_last,
                    output ready);
endinterface

### hw/rtl/sha512_ctrl.sv
// Sequencer of the SHA-512 engine: word intake, padding, rounds, digest hand-off.
// Depends on sha512_pkg; drives sha512_dp through t_dp_cmd.
module sha512_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_final_word,
    input  logic [sha512_pkg::CNT_W-1:0] i_valid_bytes,
    output logic                         o_in_ready,
    input  sha512_pkg::t_dp_sts          i_sts,
    output sha512_pkg::t_dp_cmd          o_cmd
);
    import sha512_pkg::*;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic             r_pad, n_pad;
    logic             r_mark, n_mark;
    logic             r_len_hi, n_len_hi;
    logic             r_len_lo, n_len_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_rnd    <= '0;
            r_pad    <= 1'b0;
            r_mark   <= 1'b0;
            r_len_hi <= 1'b0;
            r_len_lo <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_rnd    <= n_rnd;
            r_pad    <= n_pad;
            r_mark   <= n_mark;
            r_len_hi <= n_len_hi;
            r_len_lo <= n_len_lo;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_rnd      = r_rnd;
        n_pad      = r_pad;
        n_mark     = r_mark;
        n_len_hi   = r_len_hi;
        n_len_lo   = r_len_lo;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.src  = SRC_DATA;
        o_cmd.rnd  = r_rnd;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.add_bytes = 1'b1;
                    n_pos           = r_pos + 1'b1;
                    if (i_final_word) begin
                        n_pad = 1'b1;
                        if (i_valid_bytes inside {[FULL_BYTES:4'hf]}) begin
                            o_cmd.src = SRC_DATA;
                            n_mark    = 1'b1;
                        end else begin
                            o_cmd.src = SRC_PADDED;
                        end
                        n_state = ST_PAD;
                    end
                    if (r_pos == POS_LAST) begin
                        o_cmd.load_work = 1'b1;
                        n_state         = ST_ROUND;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                n_pos      = r_pos + 1'b1;
                if (r_mark) begin
                    o_cmd.src = SRC_MARK;
                    n_mark    = 1'b0;
                end else if (r_pos == POS_LEN_HI) begin
                    o_cmd.src = SRC_LEN_HI;
                    n_len_hi  = 1'b1;
                end else if (r_pos == POS_LAST && r_len_hi) begin
                    o_cmd.src = SRC_LEN_LO;
                    n_len_lo  = 1'b1;
                end else begin
                    o_cmd.src = SRC_ZERO;
                end
                if (r_pos == POS_LAST) begin
                    o_cmd.load_work = 1'b1;
                    n_state         = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == LAST_ROUND) begin
                    n_rnd   = '0;
                    n_state = ST_ADD;
                end else begin
                    n_rnd = r_rnd + 1'b1;
                end
            end
            ST_ADD: begin
                o_cmd.add_hash = 1'b1;
                if (r_len_lo) begin
                    n_state = ST_DONE;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                // hold the digest until the output buffer drains
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_pad         = 1'b0;
                    n_len_hi      = 1'b0;
                    n_len_lo      = 1'b0;
                    n_pos         = '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sha512_dp.sv
// Datapath of the SHA-512 engine: schedule window, round logic, hash state,
// byte counter and digest output buffer. Depends on sha512_pkg.
module sha512_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sha512_pkg::t_dp_cmd           i_cmd,
    output sha512_pkg::t_dp_sts           o_sts,
    input  logic [sha512_pkg::WORD_W-1:0] i_data_word,
    input  logic [sha512_pkg::CNT_W-1:0]  i_valid_bytes,
    input  logic                          i_final_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sha512_pkg::WORD_W-1:0] o_digest_word,
    output logic [sha512_pkg::IDX_W-1:0]  o_digest_index,
    output logic                          o_digest_last
);
    import sha512_pkg::*;

    logic [WORD_W-1:0] r_w    [SCHED_N];
    logic [WORD_W-1:0] r_work [HASH_N];
    logic [WORD_W-1:0] r_hash [HASH_N];
    logic [WORD_W-1:0] r_buf  [HASH_N];
    logic [WORD_W-1:0] r_bytes;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_busy;

    logic [CNT_W-1:0]  w_cnt;
    logic [WORD_W-1:0] w_padded;
    logic [WORD_W-1:0] w_push;
    logic [WORD_W-1:0] w_next_sched;
    logic [WORD_W-1:0] w_t1, w_t2;
    logic              w_out_take;

    // clamp the final byte count to a full word
    assign w_cnt = i_valid_bytes[CNT_W-1] ? FULL_BYTES : i_valid_bytes;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            if (CNT_W'(j) < w_cnt) begin
                w_padded[WORD_W-1-8*j -: 8] = i_data_word[WORD_W-1-8*j -: 8];
            end else if (CNT_W'(j) == w_cnt) begin
                w_padded[WORD_W-1-8*j -: 8] = 8'h80;
            end else begin
                w_padded[WORD_W-1-8*j -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_DATA:   w_push = i_data_word;
            SRC_PADDED: w_push = w_padded;
            SRC_MARK:   w_push = MARK_WORD;
            SRC_LEN_HI: w_push = {61'd0, r_bytes[WORD_W-1 -: 3]};
            SRC_LEN_LO: w_push = {r_bytes[WORD_W-4:0], 3'b000};
            default:    w_push = '0;
        endcase
    end

    // schedule word sixteen ahead of the one consumed this round
    assign w_next_sched = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    assign w_t1 = r_work[7] + big_sigma1(r_work[4])
                + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
                + ROUND_K[i_cmd.rnd] + r_w[0];
    assign w_t2 = big_sigma0(r_work[0])
                + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round) begin
            for (int j = 0; j < SCHED_N - 1; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[SCHED_N-1] <= i_cmd.push ? w_push : w_next_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int j = 0; j < HASH_N; j++) begin
                r_work[j] <= r_hash[j];
            end
        end else if (i_cmd.round) begin
            r_work[0] <= w_t1 + w_t2;
            r_work[1] <= r_work[0];
            r_work[2] <= r_work[1];
            r_work[3] <= r_work[2];
            r_work[4] <= r_work[3] + w_t1;
            r_work[5] <= r_work[4];
            r_work[6] <= r_work[5];
            r_work[7] <= r_work[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HASH_N; j++) begin
                r_hash[j] <= INIT_HASH[j];
            end
            r_bytes <= '0;
        end else begin
            if (i_cmd.add_hash) begin
                for (int j = 0; j < HASH_N; j++) begin
                    r_hash[j] <= r_hash[j] + r_work[j];
                end
            end else if (i_cmd.publish) begin
                for (int j = 0; j < HASH_N; j++) begin
                    r_hash[j] <= INIT_HASH[j];
                end
            end
            if (i_cmd.publish) begin
                r_bytes <= '0;
            end else if (i_cmd.add_bytes) begin
                r_bytes <= r_bytes + (i_final_word ? {{(WORD_W-CNT_W){1'b0}}, w_cnt}
                                                   : WORD_W'(8));
            end
        end
    end

    assign w_out_take = r_out_busy && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            for (int j = 0; j < HASH_N; j++) begin
                r_buf[j] <= r_hash[j];
            end
        end else if (w_out_take) begin
            for (int j = 0; j < HASH_N - 1; j++) begin
                r_buf[j] <= r_buf[j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_busy <= 1'b0;
            r_idx      <= '0;
        end else if (i_cmd.publish) begin
            r_out_busy <= 1'b1;
            r_idx      <= '0;
        end else if (w_out_take) begin
            r_idx <= r_idx + 1'b1;
            if (&r_idx) begin
                r_out_busy <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_busy;
    assign o_out_valid    = r_out_busy;
    assign o_digest_word  = r_buf[0];
    assign o_digest_index = r_idx;
    assign o_digest_last  = &r_idx;

endmodule

### hw/rtl/sha512_hash_engine.sv
// Top level of the SHA-512 engine: joins the sequencer and the datapath.
// Depends on sha512_pkg, sha512_if, sha512_ctrl and sha512_dp.
//
//   channel  dir  interface      fields
//   i_msg    in   sha512_msg_if  data_word[63:0], valid_bytes[3:0], final_word
//   o_dig    out  sha512_dig_if  digest_word[63:0], digest_index[2:0], digest_last
//
// A message word is accepted whenever the sequencer is idle; every sixteenth word
// (one 128-byte block) starts a compression of 80 rounds, one per cycle in the
// round adder tree, after which the result is folded into the hash state. A final
// word adds padding words, at most one extra compression, and a copy of the
// digest into the output buffer.
// Reset (synchronous, active low) loads the initial hash values and clears the
// counters. A stalled digest sits in the buffer while new words keep coming in;
// only the next digest waits for it to drain.
module sha512_hash_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha512_msg_if.sink   i_msg,
    sha512_dig_if.source o_dig
);
    import sha512_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sha512_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_msg.valid),
        .i_final_word  (i_msg.final_word),
        .i_valid_bytes (i_msg.valid_bytes),
        .o_in_ready    (i_msg.ready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    sha512_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_data_word    (i_msg.data_word),
        .i_valid_bytes  (i_msg.valid_bytes),
        .i_final_word   (i_msg.final_word),
        .o_out_valid    (o_dig.valid),
        .i_out_ready    (o_dig.ready),
        .o_digest_word  (o_dig.digest_word),
        .o_digest_index (o_dig.digest_index),
        .o_digest_last  (o_dig.digest_last)
    );

    // no intake while rounds run on the schedule window
    a_no_intake_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.round |-> !i_msg.ready)
        else $error("message word accepted during compression rounds");

    // a new digest never overwrites one still in the buffer
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> !w_sts.out_busy)
        else $error("digest published into a busy output buffer");

    // the buffer empties right after its last word goes out
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dig.valid && o_dig.ready && o_dig.digest_last) |=> !o_dig.valid)
        else $error("digest valid after last word was taken");

    // schedule shifts from one source per cycle
    a_push_xor_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !w_cmd.round && !w_cmd.add_hash)
        else $error("schedule push collides with round or hash update");

endmodule
